>>> rtl/gsfs_pkg.sv
// ----------------------------------------------------------------------------
// gsfs_pkg
// Shared constants and codes for the gas-sensor frame smoother.
// ----------------------------------------------------------------------------
`default_nettype none

package gsfs_pkg;

    // Frame layout
    localparam int unsigned FRAME_LEN  = 9;
    localparam int unsigned KEEP_BYTES = 8;
    localparam int unsigned COUNT_SAT  = 10;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned WORD_W   = 16;
    localparam int unsigned COUNT_W  = 4;
    localparam int unsigned PTR_W    = 3;
    localparam int unsigned DIRTY_W  = 8;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [BYTE_W-1:0] HDR0 = 8'd44;
    localparam logic [BYTE_W-1:0] HDR1 = 8'd228;

    localparam logic [WORD_W-1:0] TVOC_OFFSET = 16'd1000;

    localparam logic [WORD_W-1:0]  DIRTY_LEVEL_RST = 16'd300;
    localparam logic [DIRTY_W-1:0] DIRTY_LIMIT_RST = 8'd180;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIRTY_LEVEL = 1'b0,
        CFG_DIRTY_LIMIT = 1'b1
    } t_cfg_idx;

endpackage

`default_nettype wire

>>> rtl/gsfs_in_if.sv
// ----------------------------------------------------------------------------
// gsfs_in_if
// Input channel: one UART byte per item with an end-of-burst flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface gsfs_in_if;
    logic                            valid;
    logic                            ready;
    logic [gsfs_pkg::BYTE_W-1:0]     data_byte;
    logic                            burst_end;

    modport source (output valid, output data_byte, output burst_end, input ready);
    modport sink   (input valid, input data_byte, input burst_end, output ready);
endinterface

`default_nettype wire

>>> rtl/gsfs_out_if.sv
// ----------------------------------------------------------------------------
// gsfs_out_if
// Result channel: frame status, smoothed readings and restart request.
// ----------------------------------------------------------------------------
`default_nettype none

interface gsfs_out_if;
    logic                            valid;
    logic                            ready;
    logic                            frame_ok;
    logic [gsfs_pkg::WORD_W-1:0]     tvoc_centi;
    logic [gsfs_pkg::WORD_W-1:0]     ch2o_centi;
    logic [gsfs_pkg::WORD_W-1:0]     co2_ppm;
    logic                            sensor_restart;

    modport source (output valid, output frame_ok, output tvoc_centi, output ch2o_centi,
                    output co2_ppm, output sensor_restart, input ready);
    modport sink   (input valid, input frame_ok, input tvoc_centi, input ch2o_centi,
                    input co2_ppm, input sensor_restart, output ready);
endinterface

`default_nettype wire

>>> rtl/gas_sensor_frame_smoother.sv
// ----------------------------------------------------------------------------
// gas_sensor_frame_smoother
// Collects sensor bursts, checks the frame and smooths TVOC, CH2O and CO2.
// ----------------------------------------------------------------------------
//  channel   direction  handshake       payload
//  i_in      sink       valid/ready     data_byte[7:0], burst_end
//  o_out     source     valid/ready     frame_ok, tvoc_centi, ch2o_centi,
//                                       co2_ppm, sensor_restart
//  cfg       write      i_cfg_we        i_cfg_idx, i_cfg_data[15:0]
//
// One byte is accepted per cycle. A byte passes an input register and is
// processed in the next cycle unless the input stage is stalled; a burst end then
// loads its result into the result register. Reset is synchronous and restores the register defaults. Only a
// burst end held in the input stage while the result register is full and not
// taken stalls the input.
`default_nettype none

module gas_sensor_frame_smoother (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    gsfs_in_if.sink                           i_in,
    gsfs_out_if.source                        o_out,
    input  wire                               i_cfg_we,
    input  wire [gsfs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire [gsfs_pkg::CFG_W-1:0]         i_cfg_data
);

    localparam int unsigned WW = gsfs_pkg::WORD_W;

    logic [WW-1:0]                     r_dirty_level;
    logic [gsfs_pkg::DIRTY_W-1:0]      r_dirty_limit;

    logic                              r_s1_valid, n_s1_valid;
    logic [gsfs_pkg::BYTE_W-1:0]       r_s1_byte;
    logic                              r_s1_last;

    logic [gsfs_pkg::COUNT_W-1:0]      r_count, n_count;
    logic [gsfs_pkg::BYTE_W-1:0]       r_bytes [gsfs_pkg::KEEP_BYTES];
    logic [gsfs_pkg::DIRTY_W-1:0]      r_dirty, n_dirty;
    logic [WW-1:0]                     r_tvoc_avg, n_tvoc_avg;
    logic [WW-1:0]                     r_ch2o_avg, n_ch2o_avg;
    logic [WW-1:0]                     r_co2_avg,  n_co2_avg;

    logic                              r_out_valid, n_out_valid;
    logic                              r_out_ok;
    logic                              r_out_restart;

    logic                              w_accept, w_advance, w_proc, w_emit;
    logic [gsfs_pkg::COUNT_W-1:0]      w_count_inc;
    logic                              w_ok, w_restart;
    logic [WW-1:0]                     w_tv_raw, w_tv, w_ch, w_co;
    logic [gsfs_pkg::DIRTY_W:0]        w_dirty_inc;
    logic [WW:0]                       w_sum_tv, w_sum_ch, w_sum_co;

    // The input stage only waits when a burst end has nowhere to go.
    assign w_advance  = !(r_s1_last && r_out_valid && !o_out.ready);
    assign i_in.ready = !r_s1_valid || w_advance;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_proc     = r_s1_valid && w_advance;
    assign w_emit     = w_proc && r_s1_last;

    always_comb begin
        w_count_inc = (r_count < gsfs_pkg::COUNT_W'(gsfs_pkg::COUNT_SAT))
                    ? r_count + 1'b1 : r_count;
        w_ok = (w_count_inc == gsfs_pkg::COUNT_W'(gsfs_pkg::FRAME_LEN))
            && (r_bytes[0] == gsfs_pkg::HDR0) && (r_bytes[1] == gsfs_pkg::HDR1);

        w_tv_raw = {r_bytes[2], r_bytes[3]};
        w_ch     = {r_bytes[4], r_bytes[5]};
        w_co     = {r_bytes[6], r_bytes[7]};
        w_tv     = (w_tv_raw > gsfs_pkg::TVOC_OFFSET) ? w_tv_raw - gsfs_pkg::TVOC_OFFSET
                                                      : w_tv_raw;

        w_dirty_inc = {1'b0, r_dirty} + 1'b1;
        w_restart   = 1'b0;
        n_dirty     = r_dirty;
        if (w_emit && w_ok) begin
            if (w_tv_raw >= r_dirty_level) begin
                if (w_dirty_inc >= {1'b0, r_dirty_limit}) begin
                    w_restart = 1'b1;
                    n_dirty   = '0;
                end else begin
                    n_dirty   = w_dirty_inc[gsfs_pkg::DIRTY_W-1:0];
                end
            end else begin
                n_dirty = '0;
            end
        end

        w_sum_tv = {1'b0, r_tvoc_avg} + {1'b0, w_tv} + 1'b1;
        w_sum_ch = {1'b0, r_ch2o_avg} + {1'b0, w_ch} + 1'b1;
        w_sum_co = {1'b0, r_co2_avg}  + {1'b0, w_co} + 1'b1;

        n_tvoc_avg = r_tvoc_avg;
        n_ch2o_avg = r_ch2o_avg;
        n_co2_avg  = r_co2_avg;
        if (w_emit && w_ok) begin
            // An empty TVOC average means no frame yet: load, do not blend.
            if (r_tvoc_avg == '0) begin
                n_tvoc_avg = w_tv;
                n_ch2o_avg = w_ch;
                n_co2_avg  = w_co;
            end else begin
                n_tvoc_avg = w_sum_tv[WW:1];
                n_ch2o_avg = w_sum_ch[WW:1];
                n_co2_avg  = w_sum_co[WW:1];
            end
        end

        n_count = r_count;
        if (w_proc) begin
            n_count = r_s1_last ? '0 : w_count_inc;
        end

        n_s1_valid  = w_accept ? 1'b1 : (w_advance ? 1'b0 : r_s1_valid);
        n_out_valid = w_emit ? 1'b1 : (o_out.ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dirty_level <= gsfs_pkg::DIRTY_LEVEL_RST;
            r_dirty_limit <= gsfs_pkg::DIRTY_LIMIT_RST;
            r_s1_valid    <= 1'b0;
            r_count       <= '0;
            r_dirty       <= '0;
            r_tvoc_avg    <= '0;
            r_ch2o_avg    <= '0;
            r_co2_avg     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (gsfs_pkg::t_cfg_idx'(i_cfg_idx))
                    gsfs_pkg::CFG_DIRTY_LEVEL: r_dirty_level <= i_cfg_data;
                    gsfs_pkg::CFG_DIRTY_LIMIT:
                        r_dirty_limit <= i_cfg_data[gsfs_pkg::DIRTY_W-1:0];
                    default: ;
                endcase
            end
            r_s1_valid  <= n_s1_valid;
            r_count     <= n_count;
            r_dirty     <= n_dirty;
            r_tvoc_avg  <= n_tvoc_avg;
            r_ch2o_avg  <= n_ch2o_avg;
            r_co2_avg   <= n_co2_avg;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_byte <= i_in.data_byte;
            r_s1_last <= i_in.burst_end;
        end
        if (w_proc && (r_count < gsfs_pkg::COUNT_W'(gsfs_pkg::KEEP_BYTES))) begin
            r_bytes[r_count[gsfs_pkg::PTR_W-1:0]] <= r_s1_byte;
        end
        if (w_emit) begin
            r_out_ok      <= w_ok;
            r_out_restart <= w_restart;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.frame_ok       = r_out_ok;
    assign o_out.sensor_restart = r_out_restart;
    // Averages only move on a result, so the state registers hold its values.
    assign o_out.tvoc_centi     = r_tvoc_avg;
    assign o_out.ch2o_centi     = r_ch2o_avg;
    assign o_out.co2_ppm        = r_co2_avg;

endmodule

`default_nettype wire

>>> rtl/gsfs_checker.sv
// ----------------------------------------------------------------------------
// gsfs_checker
// Port-level checks for the gas-sensor frame smoother.
// ----------------------------------------------------------------------------
`default_nettype none

module gsfs_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              i_in_valid,
    input wire                              i_in_ready,
    input wire                              i_in_burst_end,
    input wire                              i_out_valid,
    input wire                              i_out_ready,
    input wire                              i_out_frame_ok,
    input wire [gsfs_pkg::WORD_W-1:0]       i_out_tvoc_centi,
    input wire                              i_out_sensor_restart
);

    // A held result keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_frame_ok) && $stable(i_out_tvoc_centi))
        else $error("result changed while stalled");

    // A restart request only comes with a valid frame.
    a_restart_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_sensor_restart |-> i_out_frame_ok)
        else $error("restart without valid frame");

    // A fresh result must trace back to an accepted burst end.
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready && i_in_burst_end, 2))
        else $error("result without burst end");

    // The first edge after reset shows no result.
    a_reset_clear: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind gas_sensor_frame_smoother gsfs_checker u_gsfs_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_in_valid           (i_in.valid),
    .i_in_ready           (i_in.ready),
    .i_in_burst_end       (i_in.burst_end),
    .i_out_valid          (o_out.valid),
    .i_out_ready          (o_out.ready),
    .i_out_frame_ok       (o_out.frame_ok),
    .i_out_tvoc_centi     (o_out.tvoc_centi),
    .i_out_sensor_restart (o_out.sensor_restart)
);

`default_nettype wire
